[src/frp_pkg.sv]
// ============================================================================
// frp_pkg - shared types and constants for the flow pulse rate meter
// Item kinds, configuration register indexes, reset values, controller states
// and the command/status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package frp_pkg;

    // Item kinds carried in the func field
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_EDGE  = 2'd1,
        FUNC_CMD   = 2'd2,
        FUNC_SRST  = 2'd3
    } t_func;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ENABLE  = 2'd0,
        CFG_WINDOW  = 2'd1,
        CFG_LOCKOUT = 2'd2,
        CFG_SCALE   = 2'd3
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Register reset values
    localparam logic        ENABLE_RST  = 1'b0;
    localparam logic [19:0] WINDOW_RST  = 20'd30000;
    localparam logic [15:0] LOCKOUT_RST = 16'd200;
    localparam logic [31:0] SCALE_RST   = 32'd10000000;

    // Rate marker and saturation limit of the time-since-pulse counter
    localparam logic [15:0] RATE_INVALID = 16'hFFFF;
    localparam logic [16:0] SINCE_MAX    = 17'h1FFFF;

    // Read-count command
    localparam logic [7:0] CMD_LEN_READ  = 8'd1;
    localparam logic [7:0] CMD_CODE_READ = 8'd1;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_DIV,
        S_MUL,
        S_UPD,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;    // latch the incoming item
        logic exec;       // apply the item to the state
        logic div_start;  // start scale / elapsed
        logic mul;        // register count * quotient
        logic upd;        // commit the new rate, restart the window
        logic load_out;   // load the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_tick;    // latched item is a millisecond tick
        logic compute;    // window reached and block enabled
        logic div_done;   // quotient ready
    } t_dp_sts;

endpackage

`default_nettype wire

[src/frp_div.sv]
// ============================================================================
// frp_div - iterative 32-bit unsigned divider
// Restoring division, one quotient bit per cycle.
// A zero divisor yields an all-ones quotient.
// ============================================================================
`default_nettype none

module frp_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_quot
);

    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [32:0] w_rem_sh;
    logic        w_ge;
    logic [32:0] w_diff;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        w_rem_sh = {r_rem, r_quo[31]};
        w_ge     = (w_rem_sh >= {1'b0, r_den});
        w_diff   = w_rem_sh - {1'b0, r_den};
    end

    // Control: busy flag, step counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[31:0] : w_rem_sh[31:0];
            r_quo <= {r_quo[30:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

[src/frp_datapath.sv]
// ============================================================================
// frp_datapath - state, configuration and arithmetic of the rate meter
// Holds counters, registers and the result register; runs the divider and
// the count * quotient multiply under command of the controller.
// ============================================================================
`default_nettype none

module frp_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [frp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [frp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // item fields
    input  wire logic [1:0]                    i_func,
    input  wire logic [7:0]                    i_cmd_length,
    input  wire logic [7:0]                    i_cmd_code,
    // control
    input  wire frp_pkg::t_dp_cmd              i_cmd,
    output frp_pkg::t_dp_sts                   o_sts,
    // result payload
    output logic [15:0]                        o_flow_rate,
    output logic                               o_rate_valid,
    output logic                               o_rate_changed,
    output logic [15:0]                        o_pulse_count,
    output logic                               o_count_valid,
    output logic                               o_cmd_status
);

    // configuration registers
    logic        r_enable;
    logic [19:0] r_window;
    logic [15:0] r_lockout;
    logic [31:0] r_scale;

    // latched item
    frp_pkg::t_func r_func;
    logic [7:0]     r_len;
    logic [7:0]     r_code;

    // block state
    logic [15:0] r_pulses;
    logic [16:0] r_since;
    logic [31:0] r_elapsed;
    logic [15:0] r_rate;

    // per-item flags and product
    logic        r_changed;
    logic        r_cvalid;
    logic        r_status;
    logic [15:0] r_prod;

    // result register
    logic [15:0] r_out_rate;
    logic        r_out_rvalid;
    logic        r_out_changed;
    logic [15:0] r_out_count;
    logic        r_out_cvalid;
    logic        r_out_status;

    logic        w_div_done;
    logic [31:0] w_quot;
    logic [31:0] w_prod;

    frp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_scale),
        .i_den   (r_elapsed),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // only the low 16 bits of the product survive
    assign w_prod = {16'd0, r_pulses} * {16'd0, w_quot[15:0]};

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= frp_pkg::ENABLE_RST;
            r_window  <= frp_pkg::WINDOW_RST;
            r_lockout <= frp_pkg::LOCKOUT_RST;
            r_scale   <= frp_pkg::SCALE_RST;
        end else if (i_cfg_we) begin
            case (frp_pkg::t_cfg_idx'(i_cfg_idx))
                frp_pkg::CFG_ENABLE:  r_enable  <= i_cfg_data[0];
                frp_pkg::CFG_WINDOW:  r_window  <= i_cfg_data[19:0];
                frp_pkg::CFG_LOCKOUT: r_lockout <= i_cfg_data[15:0];
                frp_pkg::CFG_SCALE:   r_scale   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Latch the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= frp_pkg::t_func'(i_func);
            r_len  <= i_cmd_length;
            r_code <= i_cmd_code;
        end
    end

    // Advance block state per item kind; commit computed rate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulses  <= '0;
            r_since   <= '0;
            r_elapsed <= '0;
            r_rate    <= frp_pkg::RATE_INVALID;
            r_changed <= 1'b0;
            r_cvalid  <= 1'b0;
            r_status  <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_changed <= 1'b0;
                r_cvalid  <= 1'b0;
                r_status  <= 1'b0;
            end
            if (i_cmd.exec) begin
                case (r_func)
                    frp_pkg::FUNC_TICK: begin
                        r_elapsed <= r_elapsed + 32'd1;
                        if (r_since != frp_pkg::SINCE_MAX) begin
                            r_since <= r_since + 17'd1;
                        end
                    end
                    frp_pkg::FUNC_EDGE: begin
                        if (r_since > {1'b0, r_lockout}) begin
                            r_pulses <= r_pulses + 16'd1;
                            r_since  <= '0;
                        end
                    end
                    frp_pkg::FUNC_CMD: begin
                        if (r_len == frp_pkg::CMD_LEN_READ &&
                            r_code == frp_pkg::CMD_CODE_READ) begin
                            r_cvalid <= 1'b1;
                        end else begin
                            r_status <= 1'b1;
                        end
                    end
                    frp_pkg::FUNC_SRST: begin
                        r_pulses  <= '0;
                        r_elapsed <= '0;
                        r_rate    <= frp_pkg::RATE_INVALID;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.upd) begin
                r_rate    <= r_prod;
                r_changed <= (r_prod != r_rate);
                r_pulses  <= '0;
                r_elapsed <= '0;
            end
        end
    end

    // Register the product
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= w_prod[15:0];
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_rate    <= r_rate;
            r_out_rvalid  <= (r_rate != frp_pkg::RATE_INVALID);
            r_out_changed <= r_changed;
            r_out_count   <= r_pulses;
            r_out_cvalid  <= r_cvalid;
            r_out_status  <= r_status;
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.is_tick  = (r_func == frp_pkg::FUNC_TICK);
        o_sts.compute  = r_enable && (r_elapsed >= {12'd0, r_window});
        o_sts.div_done = w_div_done;
    end

    assign o_flow_rate    = r_out_rate;
    assign o_rate_valid   = r_out_rvalid;
    assign o_rate_changed = r_out_changed;
    assign o_pulse_count  = r_out_count;
    assign o_count_valid  = r_out_cvalid;
    assign o_cmd_status   = r_out_status;

endmodule

`default_nettype wire

[src/frp_ctrl.sv]
// ============================================================================
// frp_ctrl - sequencer of the flow pulse rate meter
// Takes one item at a time, steps the datapath through update, divide,
// multiply and commit, and owns the valid flag of the result register.
// ============================================================================
`default_nettype none

module frp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire frp_pkg::t_dp_sts i_sts,
    output frp_pkg::t_dp_cmd      o_cmd
);

    frp_pkg::t_state r_state;
    frp_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    // Hold state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= frp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            frp_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = frp_pkg::S_EXEC;
                end
            end
            frp_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.is_tick ? frp_pkg::S_CHECK : frp_pkg::S_DONE;
            end
            frp_pkg::S_CHECK: begin
                if (i_sts.compute) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = frp_pkg::S_DIV;
                end else begin
                    n_state = frp_pkg::S_DONE;
                end
            end
            frp_pkg::S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = frp_pkg::S_MUL;
                end
            end
            frp_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = frp_pkg::S_UPD;
            end
            frp_pkg::S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = frp_pkg::S_DONE;
            end
            frp_pkg::S_DONE: begin
                // load once the result register is free or draining
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = frp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = frp_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[src/flow_pulse_rate_meter.sv]
// ============================================================================
// flow_pulse_rate_meter - debounced pulse counter and flow rate meter
// Counts debounced sensor edges, times windows on millisecond ticks and
// turns the count into a flow rate at the end of each window.
// ============================================================================
// Input channel (i_in_valid/o_in_ready) carries one item per beat: a
// millisecond tick, a sensor falling edge, a command or a soft reset.
// Every item yields exactly one result beat on o_out_valid/i_out_ready,
// in order. Items are processed one at a time.
// Sequence: every item is latched and applied to the state, then the result
// register is loaded; a tick also checks the window, and a tick that closes a
// window first runs the bit-serial divide of rate_scale by the elapsed time,
// then a registered 16x16 multiply and a commit step. A new item is accepted
// in the cycle after the previous result is loaded.
// The result register lets the next item be taken while a result still
// waits; a stalled receiver holds the result and stops the sequencer at the
// load step until the beat is taken.
// The user must write configuration (i_cfg_we/i_cfg_idx/i_cfg_data) only while
// the block is idle; it does not enforce this. Synchronous reset restores the
// register defaults, clears the counters and marks the rate invalid.
// ============================================================================
`default_nettype none

module flow_pulse_rate_meter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_we,
    input  wire logic [frp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [frp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // item channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [1:0]                     i_func,
    input  wire logic [7:0]                     i_cmd_length,
    input  wire logic [7:0]                     i_cmd_code,
    // result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [15:0]                         o_flow_rate,
    output logic                                o_rate_valid,
    output logic                                o_rate_changed,
    output logic [15:0]                         o_pulse_count,
    output logic                                o_count_valid,
    output logic                                o_cmd_status
);

    frp_pkg::t_dp_cmd w_cmd;
    frp_pkg::t_dp_sts w_sts;

    frp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    frp_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_func),
        .i_cmd_length   (i_cmd_length),
        .i_cmd_code     (i_cmd_code),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_flow_rate    (o_flow_rate),
        .o_rate_valid   (o_rate_valid),
        .o_rate_changed (o_rate_changed),
        .o_pulse_count  (o_pulse_count),
        .o_count_valid  (o_count_valid),
        .o_cmd_status   (o_cmd_status)
    );

endmodule

`default_nettype wire

[src/frp_checker.sv]
// ============================================================================
// frp_checker - port-level checks for the flow pulse rate meter
// Watches the top-level ports and flags results that contradict each other
// or a result beat that changes while stalled.
// ============================================================================
`default_nettype none

module frp_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic [15:0]                    o_flow_rate,
    input  wire logic                           o_rate_valid,
    input  wire logic                           o_rate_changed,
    input  wire logic [15:0]                    o_pulse_count,
    input  wire logic                           o_count_valid,
    input  wire logic                           o_cmd_status
);

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Valid flag matches the invalid-rate marker
    a_rate_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rate_valid == (o_flow_rate != frp_pkg::RATE_INVALID)))
        else $error("rate_valid disagrees with flow_rate");

    // A command is either served or rejected, never both
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_count_valid && o_cmd_status))
        else $error("command both served and rejected");

    // A fresh rate always restarts the count
    a_changed_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rate_changed) |-> (o_pulse_count == 16'd0))
        else $error("rate changed with nonzero count");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_flow_rate) && $stable(o_pulse_count)))
        else $error("stalled result changed");

endmodule

bind flow_pulse_rate_meter frp_checker u_frp_checker (.*);

`default_nettype wire

[test/tb_flow_pulse_rate_meter.sv]
// ============================================================================
// tb_flow_pulse_rate_meter - self-checking bench for the flow pulse rate meter
// Drives ticks, sensor edges, commands and soft resets through the item
// channel, predicts every result beat in-bench and compares each field of
// each beat in order. Both channels idle and stall at random, and the
// registers are rewritten between phases while the block is quiet.
// ============================================================================
`default_nettype none

module tb_flow_pulse_rate_meter;

    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned SETTLE_CYCLES = 48;

    typedef struct packed {
        logic [15:0] flow_rate;
        logic        rate_valid;
        logic        rate_changed;
        logic [15:0] pulse_count;
        logic        count_valid;
        logic        cmd_status;
    } t_meter_beat;

    // DUT signals
    logic                           i_clk;
    logic                           i_rst_n    = 1'b0;
    logic                           cfg_we     = 1'b0;
    logic [frp_pkg::CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [frp_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
    logic                           in_valid   = 1'b0;
    logic                           in_ready;
    logic [1:0]                     func       = '0;
    logic [7:0]                     cmd_length = '0;
    logic [7:0]                     cmd_code   = '0;
    logic                           out_valid;
    logic                           out_ready  = 1'b0;
    logic [15:0]                    flow_rate;
    logic                           rate_valid;
    logic                           rate_changed;
    logic [15:0]                    pulse_count;
    logic                           count_valid;
    logic                           cmd_status;

    // Predicted register values
    logic        cfg_enable_q;
    logic [19:0] cfg_window_q;
    logic [15:0] cfg_lockout_q;
    logic [31:0] cfg_scale_q;

    // Predicted meter state
    logic [15:0] cnt_pulses;
    logic [16:0] ms_since_edge;
    logic [31:0] ms_in_window;
    logic [15:0] cur_rate;

    t_meter_beat expected_beats[$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int          rx_hold     = 0;
    bit          rx_calm     = 1'b0;
    bit          tx_calm     = 1'b0;

    flow_pulse_rate_meter u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_func         (func),
        .i_cmd_length   (cmd_length),
        .i_cmd_code     (cmd_code),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_flow_rate    (flow_rate),
        .o_rate_valid   (rate_valid),
        .o_rate_changed (rate_changed),
        .o_pulse_count  (pulse_count),
        .o_count_valid  (count_valid),
        .o_cmd_status   (cmd_status)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stop a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("tb_flow_pulse_rate_meter: FAIL");
        $finish;
    end

    // Mostly short pauses, now and then a long one
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 92)
            return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    // Advance the predicted meter by one item and return its result beat
    function automatic t_meter_beat predict_meter(frp_pkg::t_func kind,
                                                  logic [7:0] len,
                                                  logic [7:0] code);
        t_meter_beat b;
        logic [15:0] prev;
        logic [31:0] quot;
        logic [31:0] prod;
        b = '0;
        case (kind)
            frp_pkg::FUNC_TICK: begin
                ms_in_window = ms_in_window + 32'd1;
                if (ms_since_edge != frp_pkg::SINCE_MAX)
                    ms_since_edge = ms_since_edge + 17'd1;
                if (cfg_enable_q && ms_in_window >= {12'd0, cfg_window_q}) begin
                    prev = cur_rate;
                    // divide by zero yields all ones
                    quot = (ms_in_window == 32'd0) ? '1 : cfg_scale_q / ms_in_window;
                    prod = {16'd0, cnt_pulses} * quot;
                    cur_rate = prod[15:0];
                    cnt_pulses = '0;
                    ms_in_window = '0;
                    b.rate_changed = (cur_rate != prev);
                end
            end
            frp_pkg::FUNC_EDGE: begin
                if (ms_since_edge > {1'b0, cfg_lockout_q}) begin
                    cnt_pulses = cnt_pulses + 16'd1;
                    ms_since_edge = '0;
                end
            end
            frp_pkg::FUNC_CMD: begin
                if (len == frp_pkg::CMD_LEN_READ && code == frp_pkg::CMD_CODE_READ)
                    b.count_valid = 1'b1;
                else
                    b.cmd_status = 1'b1;
            end
            default: begin
                cnt_pulses = '0;
                ms_in_window = '0;
                cur_rate = frp_pkg::RATE_INVALID;
            end
        endcase
        b.flow_rate   = cur_rate;
        b.rate_valid  = (cur_rate != frp_pkg::RATE_INVALID);
        b.pulse_count = cnt_pulses;
        return b;
    endfunction

    // Send one item beat and queue its predicted result on accept
    task automatic send_item(frp_pkg::t_func kind, logic [7:0] len, logic [7:0] code);
        int gap;
        gap = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : pick_pause();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        func       <= kind;
        cmd_length <= len;
        cmd_code   <= code;
        do @(posedge i_clk); while (!in_ready);
        expected_beats.push_back(predict_meter(kind, len, code));
    endtask

    // One random item: mostly ticks and edges, some commands and soft resets
    task automatic send_random_item();
        int   r;
        frp_pkg::t_func kind;
        logic [7:0] len;
        logic [7:0] code;
        r    = $urandom_range(0, 99);
        len  = 8'($urandom);
        code = 8'($urandom);
        if (r < 45)
            kind = frp_pkg::FUNC_TICK;
        else if (r < 83)
            kind = frp_pkg::FUNC_EDGE;
        else if (r < 93) begin
            kind = frp_pkg::FUNC_CMD;
            if ($urandom_range(0, 1)) begin
                len  = frp_pkg::CMD_LEN_READ;
                code = frp_pkg::CMD_CODE_READ;
            end
        end else
            kind = frp_pkg::FUNC_SRST;
        send_item(kind, len, code);
    endtask

    // Drop valid and wait until every queued result has come back
    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge i_clk);
    endtask

    // Drain, then let the sequencer settle before touching registers
    task automatic quiesce();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register and mirror it into the predictor
    task automatic write_reg(frp_pkg::t_cfg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            frp_pkg::CFG_ENABLE:  cfg_enable_q  = data[0];
            frp_pkg::CFG_WINDOW:  cfg_window_q  = data[19:0];
            frp_pkg::CFG_LOCKOUT: cfg_lockout_q = data[15:0];
            default:              cfg_scale_q   = data;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Receiver: alternate ready runs and stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (rx_calm) begin
            out_ready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold--;
        end else if (out_ready) begin
            out_ready <= 1'b0;
            rx_hold = pick_pause() - 1;
        end else begin
            out_ready <= 1'b1;
            rx_hold = $urandom_range(0, 15);
        end
    end

    // Compare each accepted result beat with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_meter_beat want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: result beat with nothing expected (rate %0d count %0d)",
                         $time, flow_rate, pulse_count);
                mismatches++;
            end else begin
                want = expected_beats.pop_front();
                check_field("flow_rate",    want.flow_rate,    flow_rate);
                check_field("rate_valid",   want.rate_valid,   rate_valid);
                check_field("rate_changed", want.rate_changed, rate_changed);
                check_field("pulse_count",  want.pulse_count,  pulse_count);
                check_field("count_valid",  want.count_valid,  count_valid);
                check_field("cmd_status",   want.cmd_status,   cmd_status);
            end
        end
    end

    // Commands of every shape at reset settings, plus one of each other kind
    task automatic test_commands();
        send_item(frp_pkg::FUNC_CMD, frp_pkg::CMD_LEN_READ, frp_pkg::CMD_CODE_READ);
        send_item(frp_pkg::FUNC_CMD, 8'd1, 8'd0);
        send_item(frp_pkg::FUNC_CMD, 8'd0, 8'd1);
        send_item(frp_pkg::FUNC_CMD, 8'd255, 8'd255);
        send_item(frp_pkg::FUNC_CMD, 8'd2, 8'd1);
        send_item(frp_pkg::FUNC_TICK, 8'd255, 8'd255);
        send_item(frp_pkg::FUNC_EDGE, 8'd0, 8'd0);
        send_item(frp_pkg::FUNC_SRST, 8'd170, 8'd85);
    endtask

    // Windows close, rate rises then falls to zero, then repeats unchanged
    task automatic test_rate_window();
        quiesce();
        write_reg(frp_pkg::CFG_ENABLE, 32'd1);
        write_reg(frp_pkg::CFG_WINDOW, 32'd2);
        write_reg(frp_pkg::CFG_LOCKOUT, 32'd0);
        write_reg(frp_pkg::CFG_SCALE, 32'd1000);
        send_item(frp_pkg::FUNC_SRST, 8'd0, 8'd0);
        send_item(frp_pkg::FUNC_TICK, 8'd0, 8'd0);
        send_item(frp_pkg::FUNC_EDGE, 8'd0, 8'd0);
        send_item(frp_pkg::FUNC_TICK, 8'd0, 8'd0);
        repeat (4) send_item(frp_pkg::FUNC_TICK, 8'd0, 8'd0);
    endtask

    // Full-scale numerator: product wraps, and a rate of all ones reads invalid
    task automatic test_product_wrap();
        quiesce();
        write_reg(frp_pkg::CFG_SCALE, 32'hFFFF_FFFF);
        write_reg(frp_pkg::CFG_WINDOW, 32'd1);
        send_item(frp_pkg::FUNC_EDGE, 8'd0, 8'd0);
        send_item(frp_pkg::FUNC_TICK, 8'd0, 8'd0);
        quiesce();
        write_reg(frp_pkg::CFG_WINDOW, 32'd3);
        send_item(frp_pkg::FUNC_TICK, 8'd0, 8'd0);
        send_item(frp_pkg::FUNC_EDGE, 8'd0, 8'd0);
        send_item(frp_pkg::FUNC_TICK, 8'd0, 8'd0);
        send_item(frp_pkg::FUNC_EDGE, 8'd0, 8'd0);
        send_item(frp_pkg::FUNC_TICK, 8'd0, 8'd0);
    endtask

    // Junk in high bits is masked off; zero window and zero scale
    task automatic test_register_masking();
        quiesce();
        write_reg(frp_pkg::CFG_WINDOW, 32'hFFF0_0000);
        write_reg(frp_pkg::CFG_LOCKOUT, 32'hFFFF_0000);
        write_reg(frp_pkg::CFG_SCALE, 32'd0);
        write_reg(frp_pkg::CFG_ENABLE, 32'hFFFF_FFFE);
        write_reg(frp_pkg::CFG_ENABLE, 32'd3);
        send_item(frp_pkg::FUNC_TICK, 8'd0, 8'd0);
        send_item(frp_pkg::FUNC_EDGE, 8'd0, 8'd0);
        send_item(frp_pkg::FUNC_TICK, 8'd0, 8'd0);
    endtask

    // Random register values, extremes included, with junk in unused bits
    task automatic set_random_config();
        logic [31:0] junk;
        logic [31:0] val;
        quiesce();
        junk = $urandom_range(0, 1) ? $urandom : 32'd0;
        write_reg(frp_pkg::CFG_ENABLE,
                  ($urandom_range(0, 9) != 0) | (junk & 32'hFFFF_FFFE));
        case ($urandom_range(0, 9))
            0:       val = 32'd1;
            1:       val = 32'd1000000;
            2:       val = 32'd0;
            default: val = $urandom_range(1, 24);
        endcase
        write_reg(frp_pkg::CFG_WINDOW, val | (junk & 32'hFFF0_0000));
        case ($urandom_range(0, 9))
            0:       val = 32'd65535;
            1:       val = 32'd0;
            default: val = $urandom_range(0, 6);
        endcase
        write_reg(frp_pkg::CFG_LOCKOUT, val | (junk & 32'hFFFF_0000));
        case ($urandom_range(0, 7))
            0:       val = 32'hFFFF_FFFF;
            1:       val = 32'd0;
            2:       val = 32'd1;
            3:       val = frp_pkg::SCALE_RST;
            default: val = $urandom;
        endcase
        write_reg(frp_pkg::CFG_SCALE, val);
    endtask

    // Phases of random traffic, each under fresh settings and idling style
    task automatic test_random_traffic();
        for (int phase = 0; phase < 10; phase++) begin
            set_random_config();
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 120; n++) begin
                send_random_item();
                if ($urandom_range(0, 149) == 0)
                    drain_results();
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // Sender holds off mid-stream until every result is back
    task automatic test_drain_pause();
        set_random_config();
        write_reg(frp_pkg::CFG_ENABLE, 32'd1);
        write_reg(frp_pkg::CFG_WINDOW, 32'd4);
        for (int n = 0; n < 40; n++)
            send_random_item();
        drain_results();
        for (int n = 0; n < 40; n++)
            send_random_item();
    endtask

    initial begin
        cfg_enable_q  = frp_pkg::ENABLE_RST;
        cfg_window_q  = frp_pkg::WINDOW_RST;
        cfg_lockout_q = frp_pkg::LOCKOUT_RST;
        cfg_scale_q   = frp_pkg::SCALE_RST;
        cnt_pulses    = '0;
        ms_since_edge = '0;
        ms_in_window  = '0;
        cur_rate      = frp_pkg::RATE_INVALID;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_commands();
        test_rate_window();
        test_product_wrap();
        test_register_masking();
        test_random_traffic();
        test_drain_pause();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_beats.size() != 0) begin
            $display("%0t: %0d result beats never arrived", $time, expected_beats.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("tb_flow_pulse_rate_meter: PASS");
        else
            $display("tb_flow_pulse_rate_meter: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
